FILE: rtl/cwm_pkg.sv
package cwm_pkg;

	// Default store geometry.
	localparam int MAX_ROWS_DEF        = 64;
	localparam int MAX_COLS_DEF        = 64;
	localparam int MAX_KERNEL_ROWS_DEF = 8;
	localparam int MAX_KERNEL_COLS_DEF = 8;

	// Fixed field widths.
	localparam int ACTION_W = 2;
	localparam int POS_W    = 6;
	localparam int VALUE_W  = 8;
	localparam int SUM_W    = 22;
	localparam int PROD_W   = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int IMG_DIM_W  = 7;
	localparam int KER_DIM_W  = 4;
	localparam int RES_DIM_W  = 7;
	localparam int BIAS_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BIAS   = 3'd6;

	// Register values after reset.
	localparam logic [IMG_DIM_W-1:0] IMAGE_HEIGHT_RST  = 7'd64;
	localparam logic [IMG_DIM_W-1:0] IMAGE_WIDTH_RST   = 7'd64;
	localparam logic [KER_DIM_W-1:0] KERNEL_HEIGHT_RST = 4'd3;
	localparam logic [KER_DIM_W-1:0] KERNEL_WIDTH_RST  = 4'd3;
	localparam logic [RES_DIM_W-1:0] RESULT_HEIGHT_RST = 7'd62;
	localparam logic [RES_DIM_W-1:0] RESULT_WIDTH_RST  = 7'd62;
	localparam logic [BIAS_W-1:0]    OFFSET_BIAS_RST   = 8'd0;

	// Action codes of an input word.
	localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TAP   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} cwm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_pixel;
		logic write_tap;
		logic query_start;
		logic tap_step;
		logic load_out;
	} cwm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_range;
		logic no_taps;
		logic last_tap;
		logic pipe_busy;
	} cwm_stat_t;

endpackage

FILE: rtl/cwm_if.sv
interface cwm_in_if;
	logic                         valid;
	logic                         ready;
	logic [cwm_pkg::ACTION_W-1:0] action;
	logic [cwm_pkg::POS_W-1:0]    pos_row;
	logic [cwm_pkg::POS_W-1:0]    pos_col;
	logic [cwm_pkg::VALUE_W-1:0]  value;

	modport source (output valid, action, pos_row, pos_col, value, input ready);
	modport sink (input valid, action, pos_row, pos_col, value, output ready);
endinterface

interface cwm_out_if;
	logic                      valid;
	logic                      ready;
	logic [cwm_pkg::SUM_W-1:0] sum;
	logic                      out_of_range;

	modport source (output valid, sum, out_of_range, input ready);
	modport sink (input valid, sum, out_of_range, output ready);
endinterface

FILE: rtl/cwm_ctrl.sv
module cwm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [cwm_pkg::ACTION_W-1:0] in_action,
	output logic                         in_ready,
	input  logic                         out_ready,
	output logic                         out_valid,
	input  cwm_pkg::cwm_stat_t           stat,
	output cwm_pkg::cwm_cmd_t            cmd
);

	cwm_pkg::cwm_state_t state_q;
	cwm_pkg::cwm_state_t state_d;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cwm_pkg::ST_IDLE: begin
				if (accept && in_action == cwm_pkg::ACT_QUERY) begin
					state_d = cwm_pkg::ST_WALK;
				end
			end
			cwm_pkg::ST_WALK: begin
				if (!stat.in_range) begin
					state_d = cwm_pkg::ST_FINISH;
				end else if (stat.no_taps || stat.last_tap) begin
					state_d = cwm_pkg::ST_DRAIN;
				end
			end
			cwm_pkg::ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = cwm_pkg::ST_FINISH;
				end
			end
			cwm_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = cwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cwm_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs and commands.
	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		case (state_q)
			cwm_pkg::ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.write_pixel = in_valid && in_action == cwm_pkg::ACT_PIXEL;
				cmd.write_tap   = in_valid && in_action == cwm_pkg::ACT_TAP;
				cmd.query_start = in_valid && in_action == cwm_pkg::ACT_QUERY;
			end
			cwm_pkg::ST_WALK: begin
				cmd.tap_step = stat.in_range && !stat.no_taps;
			end
			cwm_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			cwm_pkg::ST_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The result word stays valid until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/cwm_dp.sv
module cwm_dp #(
	parameter int MAX_ROWS        = cwm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS        = cwm_pkg::MAX_COLS_DEF,
	parameter int MAX_KERNEL_ROWS = cwm_pkg::MAX_KERNEL_ROWS_DEF,
	parameter int MAX_KERNEL_COLS = cwm_pkg::MAX_KERNEL_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cwm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [cwm_pkg::POS_W-1:0]      in_pos_row,
	input  logic [cwm_pkg::POS_W-1:0]      in_pos_col,
	input  logic [cwm_pkg::VALUE_W-1:0]    in_value,
	output logic [cwm_pkg::SUM_W-1:0]      out_sum,
	output logic                           out_out_of_range,
	input  cwm_pkg::cwm_cmd_t              cmd,
	output cwm_pkg::cwm_stat_t             stat
);

	// Widths of image coordinates and clamped sizes.
	localparam int ROW_W = ($clog2(MAX_ROWS + 1) > cwm_pkg::IMG_DIM_W) ?
		$clog2(MAX_ROWS + 1) : cwm_pkg::IMG_DIM_W;
	localparam int COL_W = ($clog2(MAX_COLS + 1) > cwm_pkg::IMG_DIM_W) ?
		$clog2(MAX_COLS + 1) : cwm_pkg::IMG_DIM_W;
	// Tap counts run 0..MAX_KERNEL_*; tap indexes run below that.
	localparam int NR_W = $clog2(MAX_KERNEL_ROWS + 1);
	localparam int NC_W = $clog2(MAX_KERNEL_COLS + 1);
	localparam int KY_W = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
	localparam int KX_W = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
	localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int KER_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
	localparam int IA_W = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KA_W = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
	localparam int VALUE_W_L = cwm_pkg::VALUE_W;

	// Configuration registers.
	logic [cwm_pkg::IMG_DIM_W-1:0] image_height_q;
	logic [cwm_pkg::IMG_DIM_W-1:0] image_width_q;
	logic [cwm_pkg::KER_DIM_W-1:0] kernel_height_q;
	logic [cwm_pkg::KER_DIM_W-1:0] kernel_width_q;
	logic [cwm_pkg::RES_DIM_W-1:0] result_height_q;
	logic [cwm_pkg::RES_DIM_W-1:0] result_width_q;
	logic [cwm_pkg::BIAS_W-1:0]    offset_bias_q;

	// Query context.
	logic [cwm_pkg::POS_W-1:0] row_q;
	logic [cwm_pkg::POS_W-1:0] col_q;
	logic                      in_range_q;
	logic [NR_W-1:0]           nrows_q;
	logic [NC_W-1:0]           ncols_q;
	logic [KY_W-1:0]           ky_q;
	logic [KX_W-1:0]           kx_q;

	// Window bounds for a new query.
	logic [ROW_W-1:0] ih;
	logic [COL_W-1:0] iw;
	logic [ROW_W-1:0] kh;
	logic [COL_W-1:0] kw;
	logic [ROW_W-1:0] row_ext;
	logic [COL_W-1:0] col_ext;
	logic [ROW_W-1:0] rows_left;
	logic [COL_W-1:0] cols_left;
	logic [NR_W-1:0]  nrows_d;
	logic [NC_W-1:0]  ncols_d;
	logic             in_range_d;
	logic             kx_wrap;

	// Store access.
	logic [VALUE_W_L-1:0] image_mem [IMG_DEPTH];
	logic [VALUE_W_L-1:0] kernel_mem [KER_DEPTH];
	logic [IA_W-1:0]          img_waddr;
	logic [KA_W-1:0]          ker_waddr;
	logic [IA_W-1:0]          img_raddr;
	logic [KA_W-1:0]          ker_raddr;
	logic [ROW_W-1:0]         iy;
	logic [COL_W-1:0]         ix;
	logic                     pix_ok;
	logic                     tap_ok;

	// Multiply-accumulate pipeline.
	logic [VALUE_W_L-1:0]      img_s1;
	logic [VALUE_W_L-1:0]      ker_s1;
	logic                      tap_s1;
	logic [cwm_pkg::PROD_W-1:0] prod_s2;
	logic                      tap_s2;
	logic [cwm_pkg::SUM_W-1:0] acc_q;
	logic [cwm_pkg::SUM_W-1:0] sum_q;
	logic                      oor_q;

	// Register writes; unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q  <= cwm_pkg::IMAGE_HEIGHT_RST;
			image_width_q   <= cwm_pkg::IMAGE_WIDTH_RST;
			kernel_height_q <= cwm_pkg::KERNEL_HEIGHT_RST;
			kernel_width_q  <= cwm_pkg::KERNEL_WIDTH_RST;
			result_height_q <= cwm_pkg::RESULT_HEIGHT_RST;
			result_width_q  <= cwm_pkg::RESULT_WIDTH_RST;
			offset_bias_q   <= cwm_pkg::OFFSET_BIAS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cwm_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[cwm_pkg::IMG_DIM_W-1:0];
				cwm_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[cwm_pkg::IMG_DIM_W-1:0];
				cwm_pkg::REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[cwm_pkg::KER_DIM_W-1:0];
				cwm_pkg::REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[cwm_pkg::KER_DIM_W-1:0];
				cwm_pkg::REG_RESULT_HEIGHT: result_height_q <= cfg_data[cwm_pkg::RES_DIM_W-1:0];
				cwm_pkg::REG_RESULT_WIDTH:  result_width_q  <= cfg_data[cwm_pkg::RES_DIM_W-1:0];
				cwm_pkg::REG_OFFSET_BIAS:   offset_bias_q   <= cfg_data[cwm_pkg::BIAS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the sizes to the stores and count the window rows and columns
	// that fall inside the image.
	always_comb begin
		ih = (ROW_W'(image_height_q) > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
			: ROW_W'(image_height_q);
		iw = (COL_W'(image_width_q) > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS)
			: COL_W'(image_width_q);
		kh = (ROW_W'(kernel_height_q) > ROW_W'(MAX_KERNEL_ROWS)) ?
			ROW_W'(MAX_KERNEL_ROWS) : ROW_W'(kernel_height_q);
		kw = (COL_W'(kernel_width_q) > COL_W'(MAX_KERNEL_COLS)) ?
			COL_W'(MAX_KERNEL_COLS) : COL_W'(kernel_width_q);
		row_ext   = ROW_W'(in_pos_row);
		col_ext   = COL_W'(in_pos_col);
		rows_left = ih - row_ext;
		cols_left = iw - col_ext;
		if (row_ext >= ih) begin
			nrows_d = '0;
		end else if (rows_left < kh) begin
			nrows_d = NR_W'(rows_left);
		end else begin
			nrows_d = NR_W'(kh);
		end
		if (col_ext >= iw) begin
			ncols_d = '0;
		end else if (cols_left < kw) begin
			ncols_d = NC_W'(cols_left);
		end else begin
			ncols_d = NC_W'(kw);
		end
		in_range_d = (cwm_pkg::RES_DIM_W'(in_pos_row) < result_height_q) &&
			(cwm_pkg::RES_DIM_W'(in_pos_col) < result_width_q);
	end

	assign kx_wrap = (NC_W'(kx_q) + NC_W'(1)) == ncols_q;

	// Query context and tap counters.
	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			row_q      <= in_pos_row;
			col_q      <= in_pos_col;
			in_range_q <= in_range_d;
			nrows_q    <= nrows_d;
			ncols_q    <= ncols_d;
			ky_q       <= '0;
			kx_q       <= '0;
		end else if (cmd.tap_step) begin
			if (kx_wrap) begin
				kx_q <= '0;
				ky_q <= ky_q + KY_W'(1);
			end else begin
				kx_q <= kx_q + KX_W'(1);
			end
		end
	end

	always_comb begin
		stat.in_range  = in_range_q;
		stat.no_taps   = (nrows_q == '0) || (ncols_q == '0);
		stat.last_tap  = kx_wrap && ((NR_W'(ky_q) + NR_W'(1)) == nrows_q);
		stat.pipe_busy = tap_s1 || tap_s2;
	end

	// Store addresses.
	always_comb begin
		pix_ok    = (ROW_W'(in_pos_row) < ROW_W'(MAX_ROWS)) &&
			(COL_W'(in_pos_col) < COL_W'(MAX_COLS));
		tap_ok    = (ROW_W'(in_pos_row) < ROW_W'(MAX_KERNEL_ROWS)) &&
			(COL_W'(in_pos_col) < COL_W'(MAX_KERNEL_COLS));
		img_waddr = IA_W'(IA_W'(in_pos_row) * IA_W'(MAX_COLS)) + IA_W'(in_pos_col);
		ker_waddr = KA_W'(KA_W'(in_pos_row) * KA_W'(MAX_KERNEL_COLS)) + KA_W'(in_pos_col);
		iy        = ROW_W'(row_q) + ROW_W'(ky_q);
		ix        = COL_W'(col_q) + COL_W'(kx_q);
		img_raddr = IA_W'(IA_W'(iy) * IA_W'(MAX_COLS)) + IA_W'(ix);
		ker_raddr = KA_W'(KA_W'(ky_q) * KA_W'(MAX_KERNEL_COLS)) + KA_W'(kx_q);
	end

	// Image store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write_pixel && pix_ok) begin
			image_mem[img_waddr] <= in_value;
		end
		img_s1 <= image_mem[img_raddr];
	end

	// Filter store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write_tap && tap_ok) begin
			kernel_mem[ker_waddr] <= in_value;
		end
		ker_s1 <= kernel_mem[ker_raddr];
	end

	// Tap valid flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= cmd.tap_step;
			tap_s2 <= tap_s1;
		end
	end

	// Product stage and accumulator.
	always_ff @(posedge clk) begin
		prod_s2 <= cwm_pkg::PROD_W'(ker_s1) * cwm_pkg::PROD_W'(img_s1);
		if (cmd.query_start) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + cwm_pkg::SUM_W'(prod_s2);
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sum_q <= in_range_q ? acc_q + cwm_pkg::SUM_W'(offset_bias_q) : '0;
			oor_q <= !in_range_q;
		end
	end

	assign out_sum          = sum_q;
	assign out_out_of_range = oor_q;

endmodule

FILE: rtl/conv2d_uint8_window_mac.sv
// Channel  Dir  Handshake      Word
// in_ch    in   valid/ready    action, pos_row, pos_col, value
// out_ch   out  valid/ready    sum, out_of_range
// cfg      in   cfg_we only    cfg_index, cfg_data
//
// Writes give no word; a query walks its taps, one multiply-accumulate per tap
// behind a two-stage read and multiply pipeline, and steps no tap when no tap
// falls inside the image or when the query is out of range.
// arst_n resets the controller and the configuration registers; the stores are not cleared.
// A finished query holds in_ch off until a stalled sink frees the output register;
// writes and the next query go on while a word waits there.
module conv2d_uint8_window_mac #(
	parameter int MAX_ROWS        = cwm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS        = cwm_pkg::MAX_COLS_DEF,
	parameter int MAX_KERNEL_ROWS = cwm_pkg::MAX_KERNEL_ROWS_DEF,
	parameter int MAX_KERNEL_COLS = cwm_pkg::MAX_KERNEL_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cwm_pkg::CFG_DATA_W-1:0] cfg_data,
	cwm_in_if.sink                         in_ch,
	cwm_out_if.source                      out_ch
);

	cwm_pkg::cwm_cmd_t  cmd;
	cwm_pkg::cwm_stat_t stat;

	// Sequencer.
	cwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Stores, registers and multiply-accumulate.
	cwm_dp #(
		.MAX_ROWS        (MAX_ROWS),
		.MAX_COLS        (MAX_COLS),
		.MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
		.MAX_KERNEL_COLS (MAX_KERNEL_COLS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_pos_row       (in_ch.pos_row),
		.in_pos_col       (in_ch.pos_col),
		.in_value         (in_ch.value),
		.out_sum          (out_ch.sum),
		.out_out_of_range (out_ch.out_of_range),
		.cmd              (cmd),
		.stat             (stat)
	);

endmodule

FILE: rtl/cwm_checker.sv
module cwm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [cwm_pkg::ACTION_W-1:0] in_action,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [cwm_pkg::SUM_W-1:0]    out_sum,
	input logic                         out_of_range
);

	// A result word waits until the sink takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A rejected query carries a zero sum.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> out_sum == '0)
		else $error("out-of-range word with nonzero sum");

	// A query blocks the input while it runs.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action == cwm_pkg::ACT_QUERY |=> !in_ready)
		else $error("input taken during a query");

	// Writes and ignored actions leave the input open.
	a_write_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action != cwm_pkg::ACT_QUERY |=> in_ready)
		else $error("input closed after a write");

endmodule

bind conv2d_uint8_window_mac cwm_checker u_cwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_action    (in_ch.action),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_sum      (out_ch.sum),
	.out_of_range (out_ch.out_of_range)
);
